>>> hdl/wpob_pkg.sv
// Shared types and constants for the windowed premultiplied over blend block.
// Used by wpob_front, wpob_fifo, wpob_back and the top level.
// No dependencies.
package wpob_pkg;

    // Screen dimension limit, default for the top level parameter
    localparam int MAX_SCREEN_DIM_DEF = 4096;

    // Configuration port
    localparam int REG_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_REGS   = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_WIN_X_MIN     = 3'd2,
        REG_WIN_X_MAX     = 3'd3,
        REG_WIN_Y_MIN     = 3'd4,
        REG_WIN_Y_MAX     = 3'd5
    } cfg_idx_t;

    localparam logic [REG_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
    localparam logic [REG_W-1:0] SCREEN_HEIGHT_RST = 13'd480;

    // Input beat, bg_red in the lowest bits
    typedef struct packed {
        logic [15:0] vol_alpha;
        logic [15:0] vol_blue;
        logic [15:0] vol_green;
        logic [15:0] vol_red;
        logic [7:0]  bg_blue;
        logic [7:0]  bg_green;
        logic [7:0]  bg_red;
    } in_beat_t;

    localparam int IN_DATA_W  = $bits(in_beat_t);
    localparam int OUT_DATA_W = 24;

    // Classified pixel handed from the front to the back
    typedef struct packed {
        in_beat_t pix;
        logic     blend;
        logic     row_end;
        logic     frame_end;
    } pix_item_t;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Blend arithmetic, sums in Q.15 units
    localparam int          SUM_W   = 26;
    localparam int          VPROD_W = 24;
    localparam logic [15:0] Q_ONE   = 16'h8000;
    localparam int          SUM_MAX = 255 * 32768;

endpackage

>>> hdl/wpob_front.sv
// Front end: configuration registers, raster position counters and pixel
// classification (window test, row and frame end). Depends on wpob_pkg.
module wpob_front #(
    parameter int MAX_SCREEN_DIM = wpob_pkg::MAX_SCREEN_DIM_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wpob_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wpob_pkg::REG_W-1:0]     cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [wpob_pkg::IN_DATA_W-1:0] s_tdata,
    output logic                           push,
    output wpob_pkg::pix_item_t            push_item,
    input  logic                           full
);
    import wpob_pkg::*;

    localparam int POS_W = $clog2(MAX_SCREEN_DIM);
    localparam int EW    = (POS_W + 1 > REG_W + 1) ? POS_W + 1 : REG_W + 1;
    localparam logic [EW-1:0] DIM_MAX = EW'(MAX_SCREEN_DIM);

    logic [REG_W-1:0] width_reg, height_reg;
    logic [REG_W-1:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_reg, row_next;

    in_beat_t         beat;
    logic [EW-1:0]    col_ext, row_ext, w_eff, h_eff;
    logic             in_window, last_col, last_row, accept;

    function automatic logic [EW-1:0] reg_ext(input logic [REG_W-1:0] v);
        return {{(EW-REG_W){1'b0}}, v};
    endfunction

    // Size of 0 acts as 1, oversize clamps to the limit
    function automatic logic [EW-1:0] eff_dim(input logic [REG_W-1:0] v);
        logic [EW-1:0] ve;
        ve = reg_ext(v);
        if (v == '0)
        begin
            return EW'(1);
        end
        if (ve > DIM_MAX)
        begin
            return DIM_MAX;
        end
        return ve;
    endfunction

    // Configuration writes, unknown indexes dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SCREEN_WIDTH_RST;
            height_reg <= SCREEN_HEIGHT_RST;
            x_min_reg  <= '0;
            x_max_reg  <= '0;
            y_min_reg  <= '0;
            y_max_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                REG_WIN_X_MIN:     x_min_reg  <= cfg_data;
                REG_WIN_X_MAX:     x_max_reg  <= cfg_data;
                REG_WIN_Y_MIN:     y_min_reg  <= cfg_data;
                REG_WIN_Y_MAX:     y_max_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Classification of the current pixel
    assign beat    = in_beat_t'(s_tdata);
    assign col_ext = {{(EW-POS_W){1'b0}}, col_reg};
    assign row_ext = {{(EW-POS_W){1'b0}}, row_reg};
    assign w_eff   = eff_dim(width_reg);
    assign h_eff   = eff_dim(height_reg);

    assign in_window = (col_ext >= reg_ext(x_min_reg)) && (col_ext < reg_ext(x_max_reg)) &&
                       (row_ext >= reg_ext(y_min_reg)) && (row_ext < reg_ext(y_max_reg));
    assign last_col = col_ext >= (w_eff - EW'(1));
    assign last_row = row_ext >= (h_eff - EW'(1));

    assign s_tready = !full;
    assign accept   = s_tvalid && !full;
    assign push     = accept;

    always_comb
    begin
        push_item.pix       = beat;
        push_item.blend     = in_window && (beat.vol_alpha != '0);
        push_item.row_end   = last_col;
        push_item.frame_end = last_col && last_row;
    end

    // Raster counters
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + POS_W'(1);
            end
            else
            begin
                col_next = col_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

>>> hdl/wpob_fifo.sv
// Short queue of classified pixels between the front and the back.
// Depends on wpob_pkg.
module wpob_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  wpob_pkg::pix_item_t push_item,
    output logic                full,
    input  logic                pop,
    output wpob_pkg::pix_item_t pop_item,
    output logic                not_empty
);
    import wpob_pkg::*;

    pix_item_t          mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
    endfunction

    assign full      = count_reg == Q_CNT_W'(Q_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_item  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + Q_CNT_W'(1)))
        else $error("queue count did not advance on push");

endmodule

>>> hdl/wpob_back.sv
// Back end: two stage blend pipeline (products, then sum and clamp) ending
// in the output register. Depends on wpob_pkg.
module wpob_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  wpob_pkg::pix_item_t             q_item,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wpob_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                            m_tlast,
    output logic                            m_tuser
);
    import wpob_pkg::*;

    localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(SUM_MAX);

    // Stage 1 registers
    logic                      s1_valid_reg, s1_valid_next;
    logic [2:0][7:0]           s1_bg_reg;
    logic                      s1_blend_reg, s1_row_end_reg, s1_frame_end_reg;
    logic signed [SUM_W-1:0]   s1_bprod_reg [3];
    logic [VPROD_W-1:0]        s1_vprod_reg [3];

    // Output registers
    logic                      m_valid_reg, m_valid_next;
    logic [2:0][7:0]           m_data_reg;
    logic                      m_last_reg, m_user_reg;

    logic                      s1_ready, s2_ready;
    logic [2:0][7:0]           bg_ch;
    logic [2:0][15:0]          vol_ch;
    logic signed [SUM_W-1:0]   weight;
    logic signed [SUM_W-1:0]   bprod [3];
    logic [VPROD_W-1:0]        vprod [3];
    logic [2:0][7:0]           blend_ch;

    // Handshake through the pipeline
    assign s2_ready      = !m_valid_reg || m_tready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign q_pop         = q_valid && s1_ready;
    assign s1_valid_next = s1_ready ? q_valid : s1_valid_reg;
    assign m_valid_next  = s2_ready ? s1_valid_reg : m_valid_reg;

    // Stage 1: bg * (1 - alpha) and vol * 255 per channel
    assign bg_ch  = {q_item.pix.bg_blue, q_item.pix.bg_green, q_item.pix.bg_red};
    assign vol_ch = {q_item.pix.vol_blue, q_item.pix.vol_green, q_item.pix.vol_red};
    assign weight = $signed({{(SUM_W-16){1'b0}}, Q_ONE})
                  - $signed({{(SUM_W-16){1'b0}}, q_item.pix.vol_alpha});

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            bprod[c] = $signed({{(SUM_W-8){1'b0}}, bg_ch[c]}) * weight;
            vprod[c] = {vol_ch[c], 8'h00} - {8'h00, vol_ch[c]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_bg_reg        <= bg_ch;
            s1_blend_reg     <= q_item.blend;
            s1_row_end_reg   <= q_item.row_end;
            s1_frame_end_reg <= q_item.frame_end;
            for (int c = 0; c < 3; c++)
            begin
                s1_bprod_reg[c] <= bprod[c];
                s1_vprod_reg[c] <= vprod[c];
            end
        end
    end

    // Stage 2: sum, clamp to [0, 255.0], truncate
    always_comb
    begin
        logic signed [SUM_W-1:0] sum;
        for (int c = 0; c < 3; c++)
        begin
            sum = s1_bprod_reg[c]
                + $signed({{(SUM_W-VPROD_W){1'b0}}, s1_vprod_reg[c]});
            if (sum < 0)
            begin
                blend_ch[c] = 8'h00;
            end
            else if (sum > SUM_HI)
            begin
                blend_ch[c] = 8'hFF;
            end
            else
            begin
                blend_ch[c] = sum[22:15];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            m_data_reg <= s1_blend_reg ? blend_ch : s1_bg_reg;
            m_last_reg <= s1_row_end_reg;
            m_user_reg <= s1_frame_end_reg;
        end
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

>>> hdl/windowed_premultiplied_over_blend_top.sv
// Top level of the windowed premultiplied over blend: front, queue, back.
// Depends on wpob_pkg, wpob_front, wpob_fifo and wpob_back.
//
// Channel  | Signals                                 | Content
// ---------+-----------------------------------------+--------------------------
// cfg      | cfg_valid cfg_ready cfg_index cfg_data  | register write, 13 bits
// s (in)   | s_tvalid s_tready s_tdata               | background and volume
// m (out)  | m_tvalid m_tready m_tdata m_tlast m_tuser | blended pixel
//
// Sustained rate is one pixel per clock while the output is not stalled; each pixel
// passes the queue entry, then the product stage, then the output register.
// The blend multiply and the vol * 255 product are both registered before the sum.
// Reset clears the raster counters and loads the register defaults.
// The four entry queue and the two back end stages hold up to six pixels;
// s_tready drops only once the queue fills while the output stalls.
module windowed_premultiplied_over_blend_top #(
    parameter int MAX_SCREEN_DIM = wpob_pkg::MAX_SCREEN_DIM_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wpob_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wpob_pkg::REG_W-1:0]      cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // bg_red, bg_green, bg_blue, vol_red, vol_green, vol_blue, vol_alpha
    input  logic [wpob_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_red, out_green, out_blue
    output logic [wpob_pkg::OUT_DATA_W-1:0] m_tdata,
    // row_end
    output logic                            m_tlast,
    // frame_end
    output logic                            m_tuser
);
    import wpob_pkg::*;

    logic      push, full, pop, not_empty;
    pix_item_t push_item, pop_item;

    wpob_front #(
        .MAX_SCREEN_DIM (MAX_SCREEN_DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (push),
        .push_item (push_item),
        .full      (full)
    );

    wpob_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (not_empty)
    );

    wpob_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (not_empty),
        .q_item   (pop_item),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
